FILE: rtl/qddec_pkg.sv
// Shared types, codes and the quadrature transition table for the detent decoder.
`timescale 1ns / 1ps

package qddec_pkg;

  // Result event codes
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_BACK    = 3'd1,
    EV_CONFIRM = 3'd2,
    EV_PUSH    = 3'd3,
    EV_PLUS    = 3'd4,
    EV_MINUS   = 3'd5
  } ev_t;

  // Input item kinds
  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_TICK   = 1'b1
  } req_t;

  // Direction of one quadrature step
  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_PLUS  = 2'd1,
    DIR_MINUS = 2'd2
  } dir_t;

  // Register indexes on the configuration port (byte address bit 2)
  localparam logic REG_STEPS_PER_DETENT = 1'b0;
  localparam logic REG_HOLDOFF_TICKS    = 1'b1;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int STEPS_W    = 4;
  localparam int HOLDOFF_W  = 10;
  localparam int SAMPLE_W   = 5;
  localparam int ACC_W      = 5;

  localparam logic [STEPS_W-1:0]   STEPS_RST    = 4'd4;
  localparam logic [HOLDOFF_W-1:0] HOLDOFF_RST  = 10'd100;
  localparam logic [SAMPLE_W-1:0]  SAMPLE_RST   = 5'h1F;

  // Configuration register contents
  typedef struct packed {
    logic [STEPS_W-1:0]   steps_per_detent;
    logic [HOLDOFF_W-1:0] holdoff_ticks;
  } cfg_t;

  // Quadrature transition table, indexed by {previous BA, new BA}
  function automatic dir_t quad_dir(input logic [3:0] idx);
    dir_t d;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14:  d = DIR_PLUS;
      4'd2, 4'd4, 4'd11, 4'd13: d = DIR_MINUS;
      default:                  d = DIR_NONE;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/quadrature_detent_button_decoder_core.sv
// Top level of the quadrature encoder, detent and button decoder.
// One input transfer (a pin sample or a 1 ms tick) can be taken every clock cycle unless in_stall is
// high; each gives exactly one result transfer, registered through the input register and then the
// result register around the combinational decode logic. A stalled result register backs
// up into the input register, and in_stall rises only when both are full.
`timescale 1ns / 1ps

module quadrature_detent_button_decoder_core
  import qddec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [SAMPLE_W-1:0]   in_pin_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_event_code,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t                cfg;
  logic                s1_valid_r;
  req_t                s1_type_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic                out_valid_r;
  ev_t                 out_event_r;
  ev_t                 dec_event;
  logic                s2_ready;
  logic                s1_ready;
  logic                fire;

  qddec_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign s2_ready = !out_valid_r || !out_stall;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign fire     = s1_valid_r && s2_ready;
  assign in_stall = !s1_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_type_r   <= req_t'(in_req_type);
      s1_sample_r <= in_pin_sample;
    end
  end

  qddec_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .req_type   (s1_type_r),
    .pin_sample (s1_sample_r),
    .cfg        (cfg),
    .event_code (dec_event)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_event_r <= dec_event;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_code = out_event_r;

  // Checks
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_event_code <= EV_MINUS))
    else $error("event code out of range");

  a_tick_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_type_r == REQ_TICK) |=> (out_valid && out_event_code == EV_NONE))
    else $error("tick produced an event");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

endmodule

FILE: rtl/qddec_cfg.sv
// APB-style configuration registers of the detent decoder.
`timescale 1ns / 1ps

module qddec_cfg
  import qddec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.steps_per_detent <= STEPS_RST;
      cfg_r.holdoff_ticks    <= HOLDOFF_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_STEPS_PER_DETENT: cfg_r.steps_per_detent <= pwdata[STEPS_W-1:0];
        REG_HOLDOFF_TICKS:    cfg_r.holdoff_ticks    <= pwdata[HOLDOFF_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (paddr[2])
      REG_STEPS_PER_DETENT:
        prdata = {{(CFG_DATA_W-STEPS_W){1'b0}}, cfg_r.steps_per_detent};
      REG_HOLDOFF_TICKS:
        prdata = {{(CFG_DATA_W-HOLDOFF_W){1'b0}}, cfg_r.holdoff_ticks};
      default:
        prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/qddec_decode.sv
// Decoder state and single-pass event logic for one sample or tick.
`timescale 1ns / 1ps

module qddec_decode
  import qddec_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  req_t                req_type,
  input  logic [SAMPLE_W-1:0] pin_sample,
  input  cfg_t                cfg,
  output ev_t                 event_code
);

  logic [SAMPLE_W-1:0]  prev_r,  prev_nxt;
  logic [ACC_W-1:0]     acc_r,   acc_nxt;
  logic                 last_plus_r, last_plus_nxt;
  logic [HOLDOFF_W-1:0] hold_r,  hold_nxt;

  logic [2:0]           fell;
  dir_t                 dir;
  logic signed [ACC_W:0] acc_base;
  logic signed [ACC_W:0] acc_sum;
  logic signed [ACC_W:0] limit;
  logic                 detent;
  logic                 plus;

  assign fell  = prev_r[2:0] & ~pin_sample[2:0];
  assign dir   = quad_dir({prev_r[4:3], pin_sample[4:3]});
  assign limit = $signed({2'b00, cfg.steps_per_detent});

  // Clear the count on reversal, then add the step
  always_comb begin
    if ((!acc_r[ACC_W-1] && acc_r != '0 && dir == DIR_MINUS) ||
        (acc_r[ACC_W-1] && dir == DIR_PLUS)) begin
      acc_base = '0;
    end else begin
      acc_base = $signed({acc_r[ACC_W-1], acc_r});
    end
    case (dir)
      DIR_PLUS:  acc_sum = acc_base + 6'sd1;
      DIR_MINUS: acc_sum = acc_base - 6'sd1;
      default:   acc_sum = acc_base;
    endcase
  end

  assign plus   = (acc_sum >= limit);
  assign detent = plus || (acc_sum <= -limit);

  // Next state and event
  always_comb begin
    prev_nxt      = prev_r;
    acc_nxt       = acc_r;
    last_plus_nxt = last_plus_r;
    hold_nxt      = hold_r;
    event_code    = EV_NONE;
    if (req_type == REQ_TICK) begin
      if (hold_r != '0) begin
        hold_nxt = hold_r - 10'd1;
      end
    end else begin
      prev_nxt = pin_sample;
      if (fell[0]) begin
        event_code = EV_BACK;
      end else if (fell[1]) begin
        event_code = EV_CONFIRM;
      end else if (fell[2]) begin
        event_code = EV_PUSH;
      end else if (dir != DIR_NONE) begin
        if (detent) begin
          acc_nxt = '0;
          // drop a reversal inside the holdoff window
          if (!(hold_r != '0 && plus != last_plus_r)) begin
            last_plus_nxt = plus;
            hold_nxt      = cfg.holdoff_ticks;
            event_code    = plus ? EV_PLUS : EV_MINUS;
          end
        end else begin
          acc_nxt = acc_sum[ACC_W-1:0];
        end
      end
    end
  end

  // Hold state until an item passes through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= SAMPLE_RST;
      acc_r       <= '0;
      last_plus_r <= 1'b0;
      hold_r      <= '0;
    end else if (fire) begin
      prev_r      <= prev_nxt;
      acc_r       <= acc_nxt;
      last_plus_r <= last_plus_nxt;
      hold_r      <= hold_nxt;
    end
  end

endmodule
